### rtl/ckt_pkg.sv
// Shared constants and types for the counted key table.
// Depends on nothing; imported by the controller, datapath and top level.
package ckt_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 16;
   localparam int COUNT_W  = 16;
   localparam int SLOT_W   = 5;
   localparam int STATUS_W = 2;
   localparam int USED_W   = 5;

   localparam logic FUNC_ADD     = 1'b0;
   localparam logic FUNC_CONSUME = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic capture;
      logic look;
      logic apply;
   } ckt_cmd_type;

endpackage

### rtl/ckt_ctrl.sv
// Request sequencer for the counted key table: accept, look up, apply, respond.
// Depends on ckt_pkg; drives the datapath through ckt_cmd_type.
module ckt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ckt_pkg::ckt_cmd_type cmd
);
   import ckt_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LOOK  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) || ((state_ff == S_APPLY) && out_free));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.capture = accept;
   assign cmd.look    = (state_ff == S_LOOK);
   assign cmd.apply   = (state_ff == S_APPLY) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_LOOK;
         end
         S_LOOK: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (out_free) state_in = accept ? S_LOOK : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.apply) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/ckt_datapath.sv
// Entry storage, key compare, count update and compaction for the counted key table.
// Depends on ckt_pkg; sequenced by ckt_ctrl through ckt_cmd_type.
module ckt_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ckt_pkg::ckt_cmd_type          cmd,
   input  logic                          req_func,
   input  logic [ckt_pkg::KEY_W-1:0]     req_key,
   input  logic [ckt_pkg::COUNT_W-1:0]   req_amount,
   input  logic [ckt_pkg::SLOT_W-1:0]    req_slot,
   output logic [ckt_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_removed,
   output logic [ckt_pkg::USED_W-1:0]    rsp_used_slots
);
   import ckt_pkg::*;

   logic                func_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [COUNT_W-1:0]  amount_ff;
   logic [SLOT_W-1:0]   slot_ff;

   logic [KEY_W-1:0]    keys_ff   [CAPACITY];
   logic [COUNT_W-1:0]  counts_ff [CAPACITY];
   logic [CNT_W-1:0]    used_ff, used_in;

   logic                hit_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic                slot_ok_ff;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic                removed_ff, removed_in;
   logic [USED_W-1:0]   used_out_ff;

   logic [CAPACITY-1:0] match;
   logic [IDX_W-1:0]    match_idx;
   logic [IDX_W-1:0]    sel_idx;
   logic                slot_ok;

   logic [COUNT_W:0]    sum;
   logic [COUNT_W-1:0]  new_cnt;
   logic                do_update;
   logic                do_append;
   logic                do_remove;
   logic [IDX_W-1:0]    tail_idx;

   always_comb begin
      match_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         match[i] = (keys_ff[i] == key_ff) && (CNT_W'(i) < used_ff);
      end
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match[i]) match_idx = IDX_W'(i);
      end
      slot_ok = (32'(slot_ff) < 32'(used_ff));
      sel_idx = (func_ff == FUNC_CONSUME) ? IDX_W'(slot_ff) : match_idx;
   end

   assign tail_idx = IDX_W'(used_ff);
   assign sum      = {1'b0, cnt_ff} + {1'b0, amount_ff};

   always_comb begin
      do_update  = 1'b0;
      do_append  = 1'b0;
      do_remove  = 1'b0;
      new_cnt    = cnt_ff;
      status_in  = ST_DONE;
      removed_in = 1'b0;
      used_in    = used_ff;
      if (func_ff == FUNC_ADD) begin
         if (amount_ff == '0) begin
            status_in = ST_DONE;
         end else if (hit_ff) begin
            do_update = 1'b1;
            new_cnt   = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
         end else if (used_ff == CNT_W'(CAPACITY)) begin
            status_in = ST_FULL;
         end else begin
            do_append = 1'b1;
            used_in   = used_ff + CNT_W'(1);
         end
      end else begin
         if (!slot_ok_ff) begin
            status_in = ST_RANGE;
         end else if (cnt_ff > COUNT_W'(1)) begin
            do_update = 1'b1;
            new_cnt   = cnt_ff - COUNT_W'(1);
         end else begin
            do_remove  = 1'b1;
            removed_in = 1'b1;
            used_in    = used_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_func;
         key_ff    <= req_key;
         amount_ff <= req_amount;
         slot_ff   <= req_slot;
      end
      if (cmd.look) begin
         hit_ff     <= |match;
         idx_ff     <= sel_idx;
         cnt_ff     <= counts_ff[sel_idx];
         slot_ok_ff <= slot_ok;
      end
      if (cmd.apply) begin
         status_ff   <= status_in;
         removed_ff  <= removed_in;
         used_out_ff <= USED_W'(used_in);
         if (do_update) counts_ff[idx_ff] <= new_cnt;
         if (do_append) begin
            keys_ff[tail_idx]   <= key_ff;
            counts_ff[tail_idx] <= amount_ff;
         end
         if (do_remove) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
               if (i >= int'(idx_ff)) begin
                  keys_ff[i]   <= keys_ff[i+1];
                  counts_ff[i] <= counts_ff[i+1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (cmd.apply) begin
         used_ff <= used_in;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_removed    = removed_ff;
   assign rsp_used_slots = used_out_ff;

endmodule

### rtl/counted_key_table.sv
// Top level of the counted key table: request and response channels.
// Depends on ckt_pkg, ckt_ctrl and ckt_datapath.
//
// A request has a lookup step and an apply step: in the lookup all used keys
// are compared at once and the addressed count is read into a register; in
// the apply step the count is stacked, decremented or appended, or the later
// entries shift down one slot, and the response word is loaded into the output
// register. The next request is taken in the apply step when the output
// register is free; a stalled response holds the block after its lookup.
module counted_key_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [ckt_pkg::KEY_W-1:0]     req_key,
   input  logic [ckt_pkg::COUNT_W-1:0]   req_amount,
   input  logic [ckt_pkg::SLOT_W-1:0]    req_slot,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ckt_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_removed,
   output logic [ckt_pkg::USED_W-1:0]    rsp_used_slots
);
   import ckt_pkg::*;

   ckt_cmd_type cmd;

   ckt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ckt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_func       (req_func),
      .req_key        (req_key),
      .req_amount     (req_amount),
      .req_slot       (req_slot),
      .rsp_status     (rsp_status),
      .rsp_removed    (rsp_removed),
      .rsp_used_slots (rsp_used_slots)
   );

endmodule
